[rtl/scfl_pkg.sv]
`timescale 1ns / 1ps

package scfl_pkg;

   localparam int ADDR_W      = 18;
   localparam int CNT_W       = 31;
   localparam int BIN_W       = 4;
   localparam int NUM_BINS    = 16;
   localparam int LIMIT_W     = 7;
   localparam int BLOCKS_W    = 7;
   localparam int MEM_DEPTH   = 32768;
   localparam int MEM_AW      = 15;
   localparam int WORD_SHIFT  = 3;
   localparam int BLOCK_SHIFT = 12;
   localparam int CSR_AW      = 3;

   localparam logic [ADDR_W-1:0]   WORD_BYTES  = 18'd8;
   localparam logic [ADDR_W-1:0]   WASTE_BYTES = 18'd8;
   localparam logic [31:0]         MAX_SMALL   = 32'd248;
   localparam logic [LIMIT_W-1:0]  POOL_BLOCKS = 7'd64;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 7'd64;
   localparam logic [CNT_W-1:0]    CNT_MAX     = 31'h7FFF_FFFF;
   localparam logic [CSR_AW-1:0]   CSR_LIMIT_ADDR = 3'd0;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PREFILL = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_TOO_LARGE  = 2'd2,
      ST_LARGE_FREE = 2'd3
   } status_type;

   typedef struct packed {
      op_type             op;
      logic               too_large;
      logic [BIN_W-1:0]   bin;
      logic [7:0]         csize;
      logic [7:0]         nper;
      logic [ADDR_W-1:0]  faddr;
      logic [CNT_W-1:0]   rcount;
   } work_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_ALLOC_CHK,
      SQ_POP_WB,
      SQ_CARVE_HDR,
      SQ_CARVE_LINK,
      SQ_PF_CHECK,
      SQ_REL_CHK,
      SQ_REL_WR
   } seq_type;

   // size class of a small byte count (count must not exceed MAX_SMALL)
   function automatic logic [BIN_W-1:0] size_bin(input logic [7:0] size);
      logic [8:0] sum;
      sum = {1'b0, size} + 9'd7;
      return sum[7:4];
   endfunction

   // chunk data size of a class: 16*b + 8
   function automatic logic [7:0] bin_size(input logic [BIN_W-1:0] bin);
      return {bin, 4'b1000};
   endfunction

   // chunks per big block of a class
   function automatic logic [7:0] bin_chunks(input logic [BIN_W-1:0] bin);
      logic [7:0] n;
      unique case (bin)
         4'd0:    n = 8'd255;
         4'd1:    n = 8'd127;
         4'd2:    n = 8'd85;
         4'd3:    n = 8'd63;
         4'd4:    n = 8'd51;
         4'd5:    n = 8'd42;
         4'd6:    n = 8'd36;
         4'd7:    n = 8'd31;
         4'd8:    n = 8'd28;
         4'd9:    n = 8'd25;
         4'd10:   n = 8'd23;
         4'd11:   n = 8'd21;
         4'd12:   n = 8'd19;
         4'd13:   n = 8'd18;
         4'd14:   n = 8'd17;
         default: n = 8'd15;
      endcase
      return n;
   endfunction

endpackage

[rtl/scfl_ram.sv]
`timescale 1ns / 1ps

module scfl_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scfl_front.sv]
`timescale 1ns / 1ps

module scfl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [31:0]                  req_request_size,
   input  logic [scfl_pkg::ADDR_W-1:0]  req_free_address,
   input  logic [scfl_pkg::CNT_W-1:0]   req_request_count,
   output logic                         out_valid,
   input  logic                         out_ready,
   output scfl_pkg::work_type           out_item
);

   logic               valid_ff, valid_in;
   scfl_pkg::work_type item_ff, item_in, cls;
   logic               load;

   always_comb begin
      cls.op        = scfl_pkg::op_type'(req_operation);
      cls.too_large = req_request_size > scfl_pkg::MAX_SMALL;
      cls.bin       = scfl_pkg::size_bin(req_request_size[7:0]);
      cls.csize     = scfl_pkg::bin_size(cls.bin);
      cls.nper      = scfl_pkg::bin_chunks(cls.bin);
      cls.faddr     = req_free_address;
      cls.rcount    = req_request_count;
   end

   assign load      = !valid_ff || out_ready;
   assign req_ready = load;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = req_valid;
         item_in  = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[rtl/scfl_queue.sv]
`timescale 1ns / 1ps

module scfl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  scfl_pkg::work_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output scfl_pkg::work_type out_item
);

   scfl_pkg::work_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/scfl_back.sv]
`timescale 1ns / 1ps

module scfl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  scfl_pkg::work_type            item,
   input  logic [scfl_pkg::LIMIT_W-1:0]  pool_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scfl_pkg::ADDR_W-1:0]   rsp_chunk_address,
   output logic [scfl_pkg::CNT_W-1:0]    rsp_filled_count,
   output logic [1:0]                    rsp_status
);

   localparam int AW = scfl_pkg::ADDR_W;

   scfl_pkg::seq_type   state_ff, state_in;
   scfl_pkg::work_type  item_ff, item_in;
   logic [scfl_pkg::BIN_W-1:0]    bin_ff, bin_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [AW-1:0]                 q_ff, q_in;
   logic [7:0]                    j_ff, j_in;
   logic [scfl_pkg::CNT_W-1:0]    ful_ff, ful_in;
   logic [scfl_pkg::BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic [AW-1:0]                 heads_ff [scfl_pkg::NUM_BINS];
   logic [AW-1:0]                 heads_in [scfl_pkg::NUM_BINS];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                 rsp_addr_ff, rsp_addr_in;
   logic [scfl_pkg::CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   scfl_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          wr_en;
   logic [scfl_pkg::MEM_AW-1:0]   wr_addr, rd_addr;
   logic [AW-1:0]                 wr_data, rd_data;

   logic [scfl_pkg::LIMIT_W-1:0]  eff_limit;
   logic                          avail;
   logic [AW-1:0]                 base, bin_head, rel_hdr_addr, link, link_addr;
   logic                          last;
   logic [scfl_pkg::CNT_W-1:0]    room;

   scfl_ram #(.WIDTH(AW), .DEPTH(scfl_pkg::MEM_DEPTH)) u_chunk_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign eff_limit = (pool_limit > scfl_pkg::POOL_BLOCKS) ? scfl_pkg::POOL_BLOCKS : pool_limit;
   assign avail     = blocks_ff < eff_limit;
   assign base      = {blocks_ff[5:0], {scfl_pkg::BLOCK_SHIFT{1'b0}}};
   assign bin_head  = heads_ff[bin_ff];
   assign rel_hdr_addr = item.faddr - scfl_pkg::WORD_BYTES;
   assign last      = j_ff == (item_ff.nper - 8'd1);
   assign room      = scfl_pkg::CNT_MAX - ful_ff;
   assign link_addr = q_ff + scfl_pkg::WORD_BYTES;
   assign link      = last ? bin_head
                           : q_ff + (scfl_pkg::WORD_BYTES << 1) + {10'd0, item_ff.csize};

   assign item_ready = (state_ff == scfl_pkg::SQ_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      bin_in        = bin_ff;
      head_in       = head_ff;
      q_in          = q_ff;
      j_in          = j_ff;
      ful_in        = ful_ff;
      blocks_in     = blocks_ff;
      heads_in      = heads_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = q_ff[AW-1:scfl_pkg::WORD_SHIFT];
      wr_data       = {10'd0, item_ff.csize};
      rd_addr       = head_ff[AW-1:scfl_pkg::WORD_SHIFT];

      unique case (state_ff)
         scfl_pkg::SQ_IDLE: begin
            rd_addr = rel_hdr_addr[AW-1:scfl_pkg::WORD_SHIFT];
            if (item_valid && item_ready) begin
               item_in       = item;
               bin_in        = item.bin;
               ful_in        = '0;
               rsp_addr_in   = '0;
               rsp_cnt_in    = '0;
               rsp_status_in = scfl_pkg::ST_OK;
               unique case (item.op)
                  scfl_pkg::OP_ALLOC: begin
                     if (item.too_large) begin
                        rsp_status_in = scfl_pkg::ST_TOO_LARGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = scfl_pkg::SQ_ALLOC_CHK;
                     end
                  end
                  scfl_pkg::OP_PREFILL: begin
                     if (item.too_large) begin
                        rsp_status_in = scfl_pkg::ST_TOO_LARGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = scfl_pkg::SQ_PF_CHECK;
                     end
                  end
                  scfl_pkg::OP_RELEASE: begin
                     if (item.faddr == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = scfl_pkg::SQ_REL_CHK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         scfl_pkg::SQ_ALLOC_CHK: begin
            rd_addr = bin_head[AW-1:scfl_pkg::WORD_SHIFT];
            if (bin_head != '0) begin
               head_in  = bin_head;
               state_in = scfl_pkg::SQ_POP_WB;
            end else if (!avail) begin
               rsp_status_in = scfl_pkg::ST_EXHAUSTED;
               rsp_valid_in  = 1'b1;
               state_in      = scfl_pkg::SQ_IDLE;
            end else begin
               q_in     = base + scfl_pkg::WASTE_BYTES;
               j_in     = '0;
               state_in = scfl_pkg::SQ_CARVE_HDR;
            end
         end

         scfl_pkg::SQ_POP_WB: begin
            heads_in[bin_ff] = rd_data;
            rsp_addr_in      = head_ff;
            rsp_valid_in     = 1'b1;
            state_in         = scfl_pkg::SQ_IDLE;
         end

         scfl_pkg::SQ_CARVE_HDR: begin
            wr_en    = 1'b1;
            state_in = scfl_pkg::SQ_CARVE_LINK;
         end

         scfl_pkg::SQ_CARVE_LINK: begin
            wr_en   = 1'b1;
            wr_addr = link_addr[AW-1:scfl_pkg::WORD_SHIFT];
            wr_data = link;
            q_in    = q_ff + scfl_pkg::WORD_BYTES + {10'd0, item_ff.csize};
            j_in    = j_ff + 8'd1;
            if (last) begin
               // link the fresh block in front of the class list
               heads_in[bin_ff] = base + scfl_pkg::WASTE_BYTES + scfl_pkg::WORD_BYTES;
               blocks_in        = blocks_ff + 7'd1;
               if (item_ff.op == scfl_pkg::OP_PREFILL) begin
                  ful_in   = ful_ff + {23'd0, item_ff.nper};
                  state_in = scfl_pkg::SQ_PF_CHECK;
               end else begin
                  state_in = scfl_pkg::SQ_ALLOC_CHK;
               end
            end else begin
               state_in = scfl_pkg::SQ_CARVE_HDR;
            end
         end

         scfl_pkg::SQ_PF_CHECK: begin
            if (ful_ff >= item_ff.rcount || room < {23'd0, item_ff.nper}) begin
               rsp_cnt_in   = ful_ff;
               rsp_valid_in = 1'b1;
               state_in     = scfl_pkg::SQ_IDLE;
            end else if (!avail) begin
               rsp_cnt_in    = ful_ff;
               rsp_status_in = scfl_pkg::ST_EXHAUSTED;
               rsp_valid_in  = 1'b1;
               state_in      = scfl_pkg::SQ_IDLE;
            end else begin
               q_in     = base + scfl_pkg::WASTE_BYTES;
               j_in     = '0;
               state_in = scfl_pkg::SQ_CARVE_HDR;
            end
         end

         scfl_pkg::SQ_REL_CHK: begin
            if ({14'd0, rd_data} > scfl_pkg::MAX_SMALL) begin
               rsp_status_in = scfl_pkg::ST_LARGE_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = scfl_pkg::SQ_IDLE;
            end else begin
               bin_in   = scfl_pkg::size_bin(rd_data[7:0]);
               state_in = scfl_pkg::SQ_REL_WR;
            end
         end

         scfl_pkg::SQ_REL_WR: begin
            wr_en            = 1'b1;
            wr_addr          = item_ff.faddr[AW-1:scfl_pkg::WORD_SHIFT];
            wr_data          = bin_head;
            heads_in[bin_ff] = item_ff.faddr;
            rsp_valid_in     = 1'b1;
            state_in         = scfl_pkg::SQ_IDLE;
         end

         default: begin
            state_in = scfl_pkg::SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scfl_pkg::SQ_IDLE;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < scfl_pkg::NUM_BINS; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      item_ff       <= item_in;
      bin_ff        <= bin_in;
      head_ff       <= head_in;
      q_ff          <= q_in;
      j_ff          <= j_in;
      ful_ff        <= ful_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chunk_address = rsp_addr_ff;
   assign rsp_filled_count  = rsp_cnt_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[rtl/size_class_free_list_allocator_top.sv]
`timescale 1ns / 1ps

// Segregated free-list allocator over an 18-bit byte pool.
// Request channel (req_*): one word per allocate, release or prefill.
// Response channel (rsp_*): exactly one word per request, in order.
// Config port (csr_*): APB-style, register 0 is pool_block_limit.
// A front stage classifies requests into size classes and feeds a
// two-entry queue; the back sequencer owns the class heads and the chunk
// memory (one write and one registered read port).
// Steps: a pop from a nonempty class passes the check and write-back
// states of the sequencer after the front register and queue; a release
// passes the check and write states; oversize and null requests answer
// straight from idle. Carving a big block takes a header write and a link
// write per chunk (they share the write port), then a new check; a prefill
// repeats that per block. The sequencer takes the next request only once
// the response has left.
// One request is in the sequencer at a time; the front keeps accepting
// until the queue is full.
// Reset clears the class heads, the block counter and all handshakes and
// sets the block limit to 64; memory contents stay undefined.
// A stalled response holds in its register and the sequencer waits for it.
module size_class_free_list_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [31:0]                  req_request_size,
   input  logic [scfl_pkg::ADDR_W-1:0]  req_free_address,
   input  logic [scfl_pkg::CNT_W-1:0]   req_request_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [scfl_pkg::ADDR_W-1:0]  rsp_chunk_address,
   output logic [scfl_pkg::CNT_W-1:0]   rsp_filled_count,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [scfl_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [scfl_pkg::LIMIT_W-1:0]  pool_limit_ff;
   logic                          fq_valid, fq_ready, qb_valid, qb_ready;
   scfl_pkg::work_type            fq_item, qb_item;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == scfl_pkg::CSR_LIMIT_ADDR);
   assign csr_prdata = (csr_paddr == scfl_pkg::CSR_LIMIT_ADDR)
                       ? {25'd0, pool_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_limit_ff <= scfl_pkg::LIMIT_RESET;
      end else if (csr_wr) begin
         pool_limit_ff <= csr_pwdata[scfl_pkg::LIMIT_W-1:0];
      end
   end

   scfl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_request_size  (req_request_size),
      .req_free_address  (req_free_address),
      .req_request_count (req_request_count),
      .out_valid         (fq_valid),
      .out_ready         (fq_ready),
      .out_item          (fq_item)
   );

   scfl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   scfl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (qb_valid),
      .item_ready        (qb_ready),
      .item              (qb_item),
      .pool_limit        (pool_limit_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chunk_address (rsp_chunk_address),
      .rsp_filled_count  (rsp_filled_count),
      .rsp_status        (rsp_status)
   );

endmodule
